/* design/pts_pkg.sv */
package pts_pkg;

    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  task_id;
        logic [4:0]  priority_req;
        logic [15:0] slice_ticks;
        logic [15:0] sleep_ticks;
    } t_pts_req;

    typedef struct packed {
        logic [4:0] running_task;
        logic       switched;
        logic       none_ready;
        logic       status;
    } t_pts_res;

    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_LAUNCH = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_DELAY  = 3'd4;
    localparam logic [2:0] CMD_BLOCK  = 3'd5;

    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [2:0] MODE_READY = 3'd1;
    localparam logic [2:0] MODE_RUN   = 3'd2;
    localparam logic [2:0] MODE_DELAY = 3'd3;
    localparam logic [2:0] MODE_BLOCK = 3'd4;

    localparam int INIT_DELAY = 10;

endpackage

/* design/pts_prio_enc.sv */
module pts_prio_enc #(
    parameter int N = 32
) (
    input  logic [N-1:0]                     i_bits,
    output logic [((N > 1) ? $clog2(N) : 1)-1:0] o_idx
);
    localparam int W = (N > 1) ? $clog2(N) : 1;

    // Lowest set bit wins: it is the highest priority.
    always_comb begin
        o_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_idx = W'(i);
            end
        end
    end

endmodule

/* design/priority_task_scheduler.sv */
// Priority task scheduler. A request is taken when start is high and busy is
// low; exactly one result follows, shown for a single cycle with o_done high,
// and the receiver cannot stall it. All task and list state sits in two
// one-port-read, one-port-write memories (a task table and a per-priority
// head/tail table), so every request is a read-modify-write sequence through
// the task table port. A tick decrements the running task's slice, walks the
// delay list through the task table port and moves each task whose delay
// expires to its ready list; it reschedules when the slice runs out or when
// no task runs but one is ready. A delay or block unlinks the running task
// from its ready list and reschedules. No clearing pass is needed after reset.
module priority_task_scheduler #(
    parameter int NUM_TASKS      = 32,
    parameter int NUM_PRIORITIES = 32,
    parameter int COUNT_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  pts_pkg::t_pts_req  i_req,
    output logic               busy,
    output logic               o_done,
    output pts_pkg::t_pts_res  o_res
);
    import pts_pkg::*;

    localparam int TA = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int TW = $clog2(NUM_TASKS + 1);
    localparam int PA = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int NP = NUM_PRIORITIES;
    localparam int CB = COUNT_BITS;

    localparam logic [TW-1:0] LIST_END = TW'(NUM_TASKS);
    localparam logic [32:0]   CMAX     = (33'd1 << COUNT_BITS) - 33'd1;
    localparam logic [NP-1:0] ONE_P    = NP'(1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ID_RD   = 5'd1;
    localparam logic [4:0] S_PU0     = 5'd2;
    localparam logic [4:0] S_PU1     = 5'd3;
    localparam logic [4:0] S_LA_CUR  = 5'd4;
    localparam logic [4:0] S_LA_CUR2 = 5'd5;
    localparam logic [4:0] S_TK_CUR  = 5'd6;
    localparam logic [4:0] S_TK_DLY0 = 5'd7;
    localparam logic [4:0] S_TK_DN   = 5'd8;
    localparam logic [4:0] S_TK_DR   = 5'd9;
    localparam logic [4:0] S_TK_PV   = 5'd10;
    localparam logic [4:0] S_TK_NX   = 5'd11;
    localparam logic [4:0] S_TK_END  = 5'd12;
    localparam logic [4:0] S_CK_CUR  = 5'd13;
    localparam logic [4:0] S_CK_FIN  = 5'd14;
    localparam logic [4:0] S_UL0     = 5'd15;
    localparam logic [4:0] S_UL1     = 5'd16;
    localparam logic [4:0] S_UL2     = 5'd17;
    localparam logic [4:0] S_UL3     = 5'd18;
    localparam logic [4:0] S_SC0     = 5'd19;
    localparam logic [4:0] S_SC1     = 5'd20;
    localparam logic [4:0] S_SC2     = 5'd21;
    localparam logic [4:0] S_SC3     = 5'd22;
    localparam logic [4:0] S_SC3B    = 5'd23;
    localparam logic [4:0] S_SC4     = 5'd24;
    localparam logic [4:0] S_SC5     = 5'd25;
    localparam logic [4:0] S_SC6     = 5'd26;
    localparam logic [4:0] S_SC7     = 5'd27;
    localparam logic [4:0] S_DONE    = 5'd28;

    typedef struct packed {
        logic [PA-1:0] prio;
        logic [CB-1:0] slice;
        logic [CB-1:0] sleft;
        logic [CB-1:0] dleft;
        logic [2:0]    mode;
        logic [TA-1:0] rnext;
        logic [TW-1:0] dnext;
    } t_trec;

    typedef struct packed {
        logic [TA-1:0] head;
        logic [TA-1:0] tail;
    } t_pent;

    function automatic logic [CB-1:0] f_sat(input logic [15:0] v);
        logic [32:0] w;
        begin
            w = 33'(v);
            if (w == 33'd0) begin
                f_sat = CB'(1);
            end else if (w > CMAX) begin
                f_sat = CMAX[CB-1:0];
            end else begin
                f_sat = w[CB-1:0];
            end
        end
    endfunction

    // Memories
    t_trec r_tmem [NUM_TASKS];
    t_pent r_pmem [NUM_PRIORITIES];
    logic [NUM_TASKS-1:0] r_tvalid;
    t_trec r_tq;
    logic  r_tqv;
    t_pent r_pq;

    logic          w_twe;
    logic [TA-1:0] w_twa;
    t_trec         w_twd;
    logic [TA-1:0] w_tra;
    logic          w_pwe;
    logic [PA-1:0] w_pwa;
    t_pent         w_pwd;
    logic [PA-1:0] w_pra;
    t_trec         w_trd;

    // Control and working registers
    logic [4:0]    r_state, n_state;
    logic [4:0]    r_ret, n_ret;
    t_pts_req      r_req, n_req;
    logic [TA-1:0] r_cur, n_cur;
    logic          r_cvalid, n_cvalid;
    logic [NP-1:0] r_bits, n_bits;
    logic [TW-1:0] r_dhead, n_dhead;
    logic          r_was_valid, n_was_valid;
    logic [TA-1:0] r_was_task, n_was_task;
    logic          r_ign, n_ign;
    logic [TA-1:0] r_t, n_t;
    t_trec         r_rec, n_rec;
    logic [TA-1:0] r_head, n_head;
    logic [TA-1:0] r_tail, n_tail;
    logic [TA-1:0] r_uprev, n_uprev;
    logic [TW-1:0] r_dprev, n_dprev;
    logic [TW-1:0] r_n, n_n;
    logic [TW-1:0] r_nx, n_nx;
    logic [TW-1:0] r_steps, n_steps;
    logic [TA-1:0] r_top, n_top;
    logic [PA-1:0] r_p, n_p;

    logic [PA-1:0] w_top_p;
    logic [6:0]    w_in_id7;
    logic          w_in_ok;
    logic [TA-1:0] w_in_idx;
    logic [4:0]    w_pr5;
    logic [PA-1:0] w_pr;
    logic [6:0]    w_cur7;
    t_trec         v_rec;

    pts_prio_enc #(.N(NP)) u_enc (
        .i_bits (r_bits),
        .o_idx  (w_top_p)
    );

    always_ff @(posedge i_clk) begin
        if (w_twe) begin
            r_tmem[w_twa] <= w_twd;
        end
        r_tq  <= (w_twe && (w_twa == w_tra)) ? w_twd : r_tmem[w_tra];
        r_tqv <= r_tvalid[w_tra] | (w_twe && (w_twa == w_tra));
        if (w_pwe) begin
            r_pmem[w_pwa] <= w_pwd;
        end
        r_pq <= (w_pwe && (w_pwa == w_pra)) ? w_pwd : r_pmem[w_pra];
    end

    // An entry never written reads as a freshly reset, stopped task.
    assign w_trd = r_tqv ? r_tq : '0;

    assign w_in_id7 = 7'(i_req.task_id);
    assign w_in_ok  = w_in_id7 < 7'(NUM_TASKS);
    assign w_in_idx = w_in_id7[TA-1:0];
    assign w_pr5    = (r_req.priority_req > 5'(NUM_PRIORITIES - 1)) ?
                      5'(NUM_PRIORITIES - 1) : r_req.priority_req;
    assign w_pr     = w_pr5[PA-1:0];

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_req       = r_req;
        n_cur       = r_cur;
        n_cvalid    = r_cvalid;
        n_bits      = r_bits;
        n_dhead     = r_dhead;
        n_was_valid = r_was_valid;
        n_was_task  = r_was_task;
        n_ign       = r_ign;
        n_t         = r_t;
        n_rec       = r_rec;
        n_head      = r_head;
        n_tail      = r_tail;
        n_uprev     = r_uprev;
        n_dprev     = r_dprev;
        n_n         = r_n;
        n_nx        = r_nx;
        n_steps     = r_steps;
        n_top       = r_top;
        n_p         = r_p;
        w_twe       = 1'b0;
        w_twa       = r_t;
        w_twd       = r_rec;
        w_tra       = r_t;
        w_pwe       = 1'b0;
        w_pwa       = r_p;
        w_pwd       = '0;
        w_pra       = r_p;
        v_rec       = w_trd;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req       = i_req;
                    n_was_valid = r_cvalid;
                    n_was_task  = r_cur;
                    n_ign       = 1'b0;
                    case (i_req.command)
                        CMD_CREATE, CMD_START, CMD_LAUNCH: begin
                            if (w_in_ok) begin
                                w_tra   = w_in_idx;
                                n_t     = w_in_idx;
                                n_state = S_ID_RD;
                            end else begin
                                n_ign   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        CMD_TICK: begin
                            w_tra   = r_cur;
                            n_state = r_cvalid ? S_TK_CUR : S_TK_DLY0;
                        end
                        CMD_DELAY, CMD_BLOCK: begin
                            if (r_cvalid) begin
                                w_tra   = r_cur;
                                n_state = S_CK_CUR;
                            end else begin
                                n_ign   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_ign   = 1'b1;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_ID_RD: begin
                case (r_req.command)
                    CMD_CREATE: begin
                        if (v_rec.mode == MODE_READY || v_rec.mode == MODE_RUN ||
                            v_rec.mode == MODE_DELAY) begin
                            n_ign = 1'b1;
                        end else begin
                            v_rec.prio  = w_pr;
                            v_rec.slice = f_sat(r_req.slice_ticks);
                            v_rec.sleft = f_sat(r_req.slice_ticks);
                            v_rec.dleft = CB'(INIT_DELAY);
                            v_rec.mode  = MODE_STOP;
                            w_twe       = 1'b1;
                            w_twd       = v_rec;
                        end
                        n_state = S_DONE;
                    end
                    CMD_START: begin
                        if (v_rec.mode != MODE_STOP && v_rec.mode != MODE_BLOCK) begin
                            n_ign   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            v_rec.mode = MODE_READY;
                            n_rec      = v_rec;
                            n_ret      = S_DONE;
                            n_state    = S_PU0;
                        end
                    end
                    default: begin
                        if (v_rec.mode == MODE_DELAY) begin
                            n_ign   = 1'b1;
                            n_state = S_DONE;
                        end else if (v_rec.mode != MODE_READY && v_rec.mode != MODE_RUN) begin
                            v_rec.mode = MODE_RUN;
                            n_rec      = v_rec;
                            n_ret      = S_LA_CUR;
                            n_state    = S_PU0;
                        end else begin
                            v_rec.mode = MODE_RUN;
                            w_twe      = 1'b1;
                            w_twd      = v_rec;
                            n_state    = S_LA_CUR;
                        end
                    end
                endcase
            end

            // Push r_t onto the head of its ready list.
            S_PU0: begin
                w_pra   = r_rec.prio;
                n_p     = r_rec.prio;
                n_state = S_PU1;
            end

            S_PU1: begin
                v_rec = r_rec;
                if (r_bits[r_p]) begin
                    v_rec.rnext = r_pq.head;
                end
                w_twe      = 1'b1;
                w_twa      = r_t;
                w_twd      = v_rec;
                w_pwe      = 1'b1;
                w_pwa      = r_p;
                w_pwd.head = r_t;
                w_pwd.tail = r_bits[r_p] ? r_pq.tail : r_t;
                n_bits     = r_bits | (ONE_P << r_p);
                n_state    = r_ret;
            end

            S_LA_CUR: begin
                if (r_cvalid && (r_cur != r_t)) begin
                    w_tra   = r_cur;
                    n_state = S_LA_CUR2;
                end else begin
                    n_cur    = r_t;
                    n_cvalid = 1'b1;
                    n_state  = S_DONE;
                end
            end

            S_LA_CUR2: begin
                if (v_rec.mode == MODE_RUN) begin
                    v_rec.mode = MODE_READY;
                    w_twe      = 1'b1;
                    w_twa      = r_cur;
                    w_twd      = v_rec;
                end
                n_cur    = r_t;
                n_cvalid = 1'b1;
                n_state  = S_DONE;
            end

            S_TK_CUR: begin
                n_state = S_TK_DLY0;
                if (v_rec.mode == MODE_RUN) begin
                    w_twe = 1'b1;
                    w_twa = r_cur;
                    if (v_rec.sleft[CB-1:1] == '0) begin
                        v_rec.sleft = v_rec.slice;
                        v_rec.mode  = MODE_READY;
                        n_ret       = S_TK_DLY0;
                        n_state     = S_SC0;
                    end else begin
                        v_rec.sleft = v_rec.sleft - CB'(1);
                    end
                    w_twd = v_rec;
                end
            end

            S_TK_DLY0: begin
                n_n     = r_dhead;
                n_dprev = LIST_END;
                n_steps = '0;
                n_state = S_TK_DN;
            end

            S_TK_DN: begin
                if ((r_n < LIST_END) && (r_steps < LIST_END)) begin
                    w_tra   = r_n[TA-1:0];
                    n_state = S_TK_DR;
                end else begin
                    n_state = S_TK_END;
                end
            end

            S_TK_DR: begin
                n_nx    = v_rec.dnext;
                n_steps = r_steps + TW'(1);
                if (v_rec.dleft[CB-1:1] == '0) begin
                    v_rec.dleft = '0;
                    v_rec.mode  = MODE_READY;
                    n_t         = r_n[TA-1:0];
                    n_rec       = v_rec;
                    n_ret       = S_TK_NX;
                    if (r_dprev == LIST_END) begin
                        n_dhead = v_rec.dnext;
                        n_state = S_PU0;
                    end else begin
                        w_tra   = r_dprev[TA-1:0];
                        n_state = S_TK_PV;
                    end
                end else begin
                    v_rec.dleft = v_rec.dleft - CB'(1);
                    w_twe       = 1'b1;
                    w_twa       = r_n[TA-1:0];
                    w_twd       = v_rec;
                    n_dprev     = r_n;
                    n_n         = v_rec.dnext;
                    n_state     = S_TK_DN;
                end
            end

            S_TK_PV: begin
                v_rec.dnext = r_nx;
                w_twe       = 1'b1;
                w_twa       = r_dprev[TA-1:0];
                w_twd       = v_rec;
                n_state     = S_PU0;
            end

            S_TK_NX: begin
                n_n     = r_nx;
                n_state = S_TK_DN;
            end

            S_TK_END: begin
                if (!r_cvalid && (r_bits != '0)) begin
                    n_ret   = S_DONE;
                    n_state = S_SC0;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_CK_CUR: begin
                if (v_rec.mode != MODE_RUN) begin
                    n_ign   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_t     = r_cur;
                    n_rec   = v_rec;
                    n_ret   = S_CK_FIN;
                    n_state = S_UL0;
                end
            end

            // Unlink r_t from its ready list.
            S_UL0: begin
                n_p = r_rec.prio;
                if (!r_bits[r_rec.prio]) begin
                    n_state = r_ret;
                end else begin
                    w_pra   = r_rec.prio;
                    n_state = S_UL1;
                end
            end

            S_UL1: begin
                n_head = r_pq.head;
                n_tail = r_pq.tail;
                if (r_pq.head == r_t) begin
                    if (r_pq.tail == r_t) begin
                        n_bits = r_bits & ~(ONE_P << r_p);
                    end else begin
                        w_pwe      = 1'b1;
                        w_pwd.head = r_rec.rnext;
                        w_pwd.tail = r_pq.tail;
                    end
                    n_state = r_ret;
                end else begin
                    n_uprev = r_pq.head;
                    n_steps = '0;
                    n_state = S_UL2;
                end
            end

            S_UL2: begin
                if ((r_steps < LIST_END) && (r_uprev != r_tail)) begin
                    w_tra   = r_uprev;
                    n_state = S_UL3;
                end else begin
                    n_state = r_ret;
                end
            end

            S_UL3: begin
                if (v_rec.rnext == r_t) begin
                    v_rec.rnext = r_rec.rnext;
                    w_twe       = 1'b1;
                    w_twa       = r_uprev;
                    w_twd       = v_rec;
                    if (r_tail == r_t) begin
                        w_pwe      = 1'b1;
                        w_pwd.head = r_head;
                        w_pwd.tail = r_uprev;
                    end
                    n_state = r_ret;
                end else begin
                    n_uprev = v_rec.rnext;
                    n_steps = r_steps + TW'(1);
                    n_state = S_UL2;
                end
            end

            S_CK_FIN: begin
                v_rec = r_rec;
                if (r_req.command == CMD_DELAY) begin
                    v_rec.dleft = f_sat(r_req.sleep_ticks);
                    v_rec.mode  = MODE_DELAY;
                    v_rec.dnext = r_dhead;
                    n_dhead     = TW'(r_cur);
                end else begin
                    v_rec.mode = MODE_BLOCK;
                end
                w_twe   = 1'b1;
                w_twa   = r_cur;
                w_twd   = v_rec;
                n_ret   = S_DONE;
                n_state = S_SC0;
            end

            // Reschedule: rotate the running task's list, then dispatch the top.
            S_SC0: begin
                if (r_cvalid) begin
                    w_tra   = r_cur;
                    n_state = S_SC1;
                end else begin
                    n_state = S_SC4;
                end
            end

            S_SC1: begin
                n_p = v_rec.prio;
                if (!r_bits[v_rec.prio]) begin
                    n_state = S_SC4;
                end else begin
                    w_pra   = v_rec.prio;
                    n_state = S_SC2;
                end
            end

            S_SC2: begin
                if (r_pq.head == r_pq.tail) begin
                    n_state = S_SC4;
                end else begin
                    n_head  = r_pq.head;
                    n_tail  = r_pq.tail;
                    w_tra   = r_pq.head;
                    n_state = S_SC3;
                end
            end

            S_SC3: begin
                w_pwe      = 1'b1;
                w_pwd.head = v_rec.rnext;
                w_pwd.tail = r_head;
                w_tra      = r_tail;
                n_state    = S_SC3B;
            end

            S_SC3B: begin
                v_rec.rnext = r_head;
                w_twe       = 1'b1;
                w_twa       = r_tail;
                w_twd       = v_rec;
                n_state     = S_SC4;
            end

            S_SC4: begin
                if (r_bits == '0) begin
                    n_cvalid = 1'b0;
                    n_state  = r_ret;
                end else begin
                    w_pra   = w_top_p;
                    n_state = S_SC5;
                end
            end

            S_SC5: begin
                n_top = r_pq.head;
                if (r_cvalid && (r_cur != r_pq.head)) begin
                    w_tra   = r_cur;
                    n_state = S_SC6;
                end else begin
                    w_tra   = r_pq.head;
                    n_state = S_SC7;
                end
            end

            S_SC6: begin
                if (v_rec.mode == MODE_RUN) begin
                    v_rec.mode = MODE_READY;
                    w_twe      = 1'b1;
                    w_twa      = r_cur;
                    w_twd      = v_rec;
                end
                w_tra   = r_top;
                n_state = S_SC7;
            end

            S_SC7: begin
                v_rec.mode = MODE_RUN;
                w_twe      = 1'b1;
                w_twa      = r_top;
                w_twd      = v_rec;
                n_cur      = r_top;
                n_cvalid   = 1'b1;
                n_state    = r_ret;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cvalid <= 1'b0;
            r_cur    <= '0;
            r_bits   <= '0;
            r_dhead  <= LIST_END;
            r_tvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_cvalid <= n_cvalid;
            r_cur    <= n_cur;
            r_bits   <= n_bits;
            r_dhead  <= n_dhead;
            if (w_twe) begin
                r_tvalid[w_twa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_req       <= n_req;
        r_was_valid <= n_was_valid;
        r_was_task  <= n_was_task;
        r_ign       <= n_ign;
        r_t         <= n_t;
        r_rec       <= n_rec;
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_uprev     <= n_uprev;
        r_dprev     <= n_dprev;
        r_n         <= n_n;
        r_nx        <= n_nx;
        r_steps     <= n_steps;
        r_top       <= n_top;
        r_p         <= n_p;
    end

    assign w_cur7 = 7'(r_cur);
    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_res.running_task = r_cvalid ? w_cur7[4:0] : 5'd0;
        o_res.switched     = (r_was_valid != r_cvalid) ||
                             (r_cvalid && (r_was_task != r_cur));
        o_res.none_ready   = (r_bits == '0);
        o_res.status       = r_ign;
    end

endmodule
